// ===== hdl/pkrm_pkg.sv =====
// ----------------------------------------------------------------------------
// pkrm_pkg
// Shared types and constants of the pair-key rule match table.
// ----------------------------------------------------------------------------
package pkrm_pkg;

  localparam int RULE_SLOTS = 128;
  localparam int IDX_W      = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int CNT_W      = $clog2(RULE_SLOTS + 1);
  localparam int KEY_W      = 32;
  localparam int ACT_W      = 4;
  localparam int USED_W     = 8;

  typedef enum logic [1:0] {
    FN_ADD    = 2'd0,
    FN_REMOVE = 2'd1,
    FN_CHECK  = 2'd2,
    FN_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_WIPE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic             vld;
    logic [KEY_W-1:0] src;
    logic [KEY_W-1:0] tgt;
    logic [ACT_W-1:0] act;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    status_t           status;
    logic [ACT_W-1:0]  found_action;
    logic [USED_W-1:0] entries_used;
  } result_t;

endpackage

// ===== hdl/pkrm_ram.sv =====
// ----------------------------------------------------------------------------
// pkrm_ram
// Single-port-write, single-port-read synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module pkrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/pkrm_ctrl.sv =====
// ----------------------------------------------------------------------------
// pkrm_ctrl
// Scan sequencer: walks the entry RAM, finds the key and the first free slot,
// then, for add and remove, updates the entry and the rule count; clears by
// writing every entry invalid, once after reset and on clear all.
// ----------------------------------------------------------------------------
module pkrm_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       func,
  input  logic [pkrm_pkg::KEY_W-1:0]       source_id,
  input  logic [pkrm_pkg::KEY_W-1:0]       target_id,
  input  logic [pkrm_pkg::ACT_W-1:0]       new_action,
  input  logic                             cfg_we,
  input  logic [pkrm_pkg::ACT_W-1:0]       cfg_wdata,
  output logic                             mem_rd_en,
  output logic [pkrm_pkg::IDX_W-1:0]       mem_rd_addr,
  input  pkrm_pkg::entry_t                 mem_rd_data,
  output logic                             mem_we,
  output logic [pkrm_pkg::IDX_W-1:0]       mem_wr_addr,
  output pkrm_pkg::entry_t                 mem_wr_data,
  output logic                             res_valid,
  input  logic                             res_ready,
  output pkrm_pkg::result_t                res
);
  import pkrm_pkg::*;

  state_t             state, state_next;
  logic [CNT_W-1:0]   cnt;
  logic               rd_pend;
  logic [IDX_W-1:0]   rd_idx;
  logic               hit;
  logic [IDX_W-1:0]   hit_idx;
  logic [ACT_W-1:0]   hit_act;
  logic               free_ok;
  logic [IDX_W-1:0]   free_idx;
  func_t              op;
  logic [KEY_W-1:0]   key_src;
  logic [KEY_W-1:0]   key_tgt;
  logic [ACT_W-1:0]   req_act;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [ACT_W-1:0]   allow_code;
  logic               full;
  logic               cnt_lt;
  logic               take;
  logic               key_eq;
  logic               wiping;
  logic               store;
  status_t            status_r;
  logic [ACT_W-1:0]   found_r;

  assign full   = (count >= CNT_W'(RULE_SLOTS));
  assign cnt_lt = (cnt < CNT_W'(RULE_SLOTS));
  assign key_eq = (mem_rd_data.src == key_src) && (mem_rd_data.tgt == key_tgt);
  assign wiping = (state == S_INIT) || (state == S_WIPE);

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    mem_rd_en   = 1'b0;
    res_valid   = 1'b0;
    case (state)
      S_INIT: begin
        if (!cnt_lt) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (func_t'(func) == FN_CLEAR) begin
            state_next = S_WIPE;
          end else if (func_t'(func) == FN_ADD && full) begin
            state_next = S_FINISH;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        mem_rd_en = cnt_lt;
        if (!cnt_lt && !rd_pend) begin
          state_next = S_FINISH;
        end
      end
      S_WIPE: begin
        if (!cnt_lt) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign mem_rd_addr = cnt[IDX_W-1:0];
  assign take        = res_valid && res_ready;

  always_comb begin
    status_r   = ST_OK;
    found_r    = '0;
    store      = 1'b0;
    count_next = count;
    case (op)
      FN_ADD: begin
        if (full) begin
          status_r = ST_FULL;
        end else if (hit) begin
          store = 1'b1;
        end else if (free_ok) begin
          store      = 1'b1;
          count_next = count + CNT_W'(1);
        end else begin
          status_r = ST_FULL;
        end
      end
      FN_REMOVE: begin
        if (hit) begin
          store = 1'b1;
          if (count != '0) begin
            count_next = count - CNT_W'(1);
          end
        end else begin
          status_r = ST_NOT_FOUND;
        end
      end
      FN_CHECK: begin
        found_r = hit ? hit_act : allow_code;
      end
      default: begin
        count_next = '0;
      end
    endcase
  end

  assign mem_we          = wiping ? cnt_lt : (take && store);
  assign mem_wr_addr     = wiping ? cnt[IDX_W-1:0] : (hit ? hit_idx : free_idx);
  assign mem_wr_data.vld = !wiping && (op == FN_ADD);
  assign mem_wr_data.src = key_src;
  assign mem_wr_data.tgt = key_tgt;
  assign mem_wr_data.act = req_act;

  assign res.status       = status_r;
  assign res.found_action = found_r;
  assign res.entries_used = USED_W'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      rd_pend    <= 1'b0;
      hit        <= 1'b0;
      free_ok    <= 1'b0;
      count      <= '0;
      allow_code <= '0;
      cnt        <= '0;
    end else begin
      state   <= state_next;
      rd_pend <= mem_rd_en;
      if (cfg_we) begin
        allow_code <= cfg_wdata;
      end
      if (in_valid && in_ready) begin
        cnt     <= '0;
        hit     <= 1'b0;
        free_ok <= 1'b0;
      end else begin
        if (mem_rd_en || (wiping && cnt_lt)) begin
          cnt <= cnt + CNT_W'(1);
        end
        if (rd_pend && mem_rd_data.vld && key_eq && !hit) begin
          hit <= 1'b1;
        end
        if (rd_pend && !mem_rd_data.vld && !free_ok) begin
          free_ok <= 1'b1;
        end
      end
      if (take) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op      <= func_t'(func);
      key_src <= source_id;
      key_tgt <= target_id;
      req_act <= new_action;
    end
    rd_idx <= cnt[IDX_W-1:0];
    if (rd_pend && mem_rd_data.vld && key_eq && !hit) begin
      hit_idx <= rd_idx;
      hit_act <= mem_rd_data.act;
    end
    if (rd_pend && !mem_rd_data.vld && !free_ok) begin
      free_idx <= rd_idx;
    end
  end

endmodule

// ===== hdl/pair_key_rule_match_table.sv =====
// ----------------------------------------------------------------------------
// pair_key_rule_match_table
// Exact-match rule table keyed by a source/target identifier pair.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_ready with func, source_id, target_id and
// new_action; one result per request leaves on out_valid/out_ready with
// status, found_action and entries_used.
// Add, remove and check read the 128 entries of the entry RAM in turn, one
// read a cycle; the next request can be taken from the time out_valid rises,
// as the table goes idle only when the result enters the output register.
// Clear all walks the RAM writing every entry invalid before out_valid rises.
// Add on a full table skips the scan and goes straight to the finish state,
// from which the result passes into the output register.
// A new request is taken while the previous result still waits in the
// output register; if the receiver stalls, the finished request holds in
// its last step, with in_ready low, until the output register frees up.
// cfg_we writes cfg_wdata into allow_code, the action returned by check
// on a miss; write it only while the table is idle.
// Reset clears the rule count and allow_code, then a 128-write pass marks
// every entry invalid; in_ready rises once that pass is done.
// ----------------------------------------------------------------------------
module pair_key_rule_match_table (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 func,
  input  logic [pkrm_pkg::KEY_W-1:0] source_id,
  input  logic [pkrm_pkg::KEY_W-1:0] target_id,
  input  logic [pkrm_pkg::ACT_W-1:0] new_action,
  input  logic                       cfg_we,
  input  logic [pkrm_pkg::ACT_W-1:0] cfg_wdata,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 status,
  output logic [pkrm_pkg::ACT_W-1:0] found_action,
  output logic [pkrm_pkg::USED_W-1:0] entries_used
);
  import pkrm_pkg::*;

  logic             mem_rd_en;
  logic [IDX_W-1:0] mem_rd_addr;
  entry_t           mem_rd_data;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wr_addr;
  entry_t           mem_wr_data;
  logic             res_valid;
  logic             res_ready;
  result_t          res;

  pkrm_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .source_id   (source_id),
    .target_id   (target_id),
    .new_action  (new_action),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_we      (mem_we),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  pkrm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RULE_SLOTS)
  ) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      status       <= res.status;
      found_action <= res.found_action;
      entries_used <= res.entries_used;
    end
  end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Randomised self-checking bench for the pair-key rule match table.
// ----------------------------------------------------------------------------
// Requests go in over the valid/ready input channel and each one is mirrored
// in a shadow rule table held by a small scoreboard class. The class works
// out the reply due for every request and checks the replies in order as they
// leave the block. A short directed sequence comes first. Three randomised
// phases follow, with a different miss action and a different idling pattern
// on each side. Random requests favour adds until eight adds have been refused
// as full, then mix adds, removes, checks and clears. In two of the phases the
// receiver holds off for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pkrm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SRC_SET_N   = 40;
  localparam int TGT_SET_N   = 48;
  localparam int PAIR_POOL_N = 192;

  class rule_table_tracker;
    bit [KEY_W-1:0] slot_src [RULE_SLOTS];
    bit [KEY_W-1:0] slot_tgt [RULE_SLOTS];
    bit [ACT_W-1:0] slot_act [RULE_SLOTS];
    bit             slot_used [RULE_SLOTS];
    int             held_rules;
    bit [ACT_W-1:0] miss_action;
    int             full_rejects;
    int             mismatches;
    result_t        pending_replies [$];

    function int find_pair(bit [KEY_W-1:0] src, bit [KEY_W-1:0] tgt);
      for (int i = 0; i < RULE_SLOTS; i++) begin
        if (slot_used[i] && slot_src[i] == src && slot_tgt[i] == tgt) return i;
      end
      return -1;
    endfunction

    function void note_request(func_t op, bit [KEY_W-1:0] src, bit [KEY_W-1:0] tgt,
                               bit [ACT_W-1:0] act);
      result_t want;
      int      hit;
      int      slot;
      want.status       = ST_OK;
      want.found_action = '0;
      case (op)
        FN_ADD: begin
          if (held_rules >= RULE_SLOTS) begin
            want.status = ST_FULL;
            full_rejects++;
          end else begin
            hit = find_pair(src, tgt);
            if (hit >= 0) begin
              slot_act[hit] = act;
            end else begin
              slot = 0;
              while (slot_used[slot]) slot++;
              slot_src[slot]  = src;
              slot_tgt[slot]  = tgt;
              slot_act[slot]  = act;
              slot_used[slot] = 1'b1;
              held_rules++;
            end
          end
        end
        FN_REMOVE: begin
          hit = find_pair(src, tgt);
          if (hit < 0) begin
            want.status = ST_NOT_FOUND;
          end else begin
            slot_used[hit] = 1'b0;
            held_rules--;
          end
        end
        FN_CHECK: begin
          hit = find_pair(src, tgt);
          want.found_action = (hit >= 0) ? slot_act[hit] : miss_action;
        end
        default: begin
          for (int i = 0; i < RULE_SLOTS; i++) slot_used[i] = 1'b0;
          held_rules = 0;
        end
      endcase
      want.entries_used = held_rules[USED_W-1:0];
      pending_replies.push_back(want);
    endfunction

    function void check_reply(logic [1:0] st, logic [ACT_W-1:0] act,
                              logic [USED_W-1:0] used);
      result_t want;
      if (pending_replies.size() == 0) begin
        mismatches++;
        $display("%0t: reply with no request outstanding: status %0d found_action %0d %s %0d",
                 $time, st, act, "entries_used", used);
        return;
      end
      want = pending_replies.pop_front();
      if (st !== want.status) begin
        mismatches++;
        $display("%0t: status expected %0d, got %0d", $time, want.status, st);
      end
      if (act !== want.found_action) begin
        mismatches++;
        $display("%0t: found_action expected %0d, got %0d", $time, want.found_action, act);
      end
      if (used !== want.entries_used) begin
        mismatches++;
        $display("%0t: entries_used expected %0d, got %0d", $time, want.entries_used, used);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          func;
  logic [KEY_W-1:0]    source_id;
  logic [KEY_W-1:0]    target_id;
  logic [ACT_W-1:0]    new_action;
  logic                cfg_we;
  logic [ACT_W-1:0]    cfg_wdata;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          status;
  logic [ACT_W-1:0]    found_action;
  logic [USED_W-1:0]   entries_used;

  rule_table_tracker tracker = new;

  bit [KEY_W-1:0] src_set [SRC_SET_N];
  bit [KEY_W-1:0] tgt_set [TGT_SET_N];
  int             send_idle_pct = 0;
  int             recv_idle_pct = 0;
  int             hold_left     = 0;
  int             cycle_count   = 0;

  pair_key_rule_match_table dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .source_id    (source_id),
    .target_id    (target_id),
    .new_action   (new_action),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .found_action (found_action),
    .entries_used (entries_used)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("pair_key_rule_match_table: mismatch");
      $finish;
    end
  end

  // hold off for a counted stretch when asked, else stall at random
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) tracker.check_reply(status, found_action, entries_used);
  end

  task automatic send_request(func_t op, bit [KEY_W-1:0] src, bit [KEY_W-1:0] tgt,
                              bit [ACT_W-1:0] act);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    func       = op;
    source_id  = src;
    target_id  = tgt;
    new_action = act;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_request(op, src, tgt, act);
  endtask

  task automatic drain_requests();
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_allow_code(bit [ACT_W-1:0] code);
    drain_requests();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = code;
    @(negedge clk);
    cfg_we = 1'b0;
    tracker.miss_action = code;
  endtask

  // fill the table until it has refused several adds, then mix operations
  task automatic random_request();
    func_t          op;
    bit [KEY_W-1:0] src;
    bit [KEY_W-1:0] tgt;
    int             roll;
    int             pick;
    roll = $urandom_range(99);
    if (tracker.full_rejects < 8) begin
      if (roll < 80) op = FN_ADD;
      else if (roll < 92) op = FN_CHECK;
      else op = FN_REMOVE;
    end else begin
      if (roll < 38) op = FN_ADD;
      else if (roll < 63) op = FN_REMOVE;
      else if (roll < 97) op = FN_CHECK;
      else op = FN_CLEAR;
    end
    pick = $urandom_range(PAIR_POOL_N - 1);
    src  = src_set[pick % SRC_SET_N];
    tgt  = tgt_set[pick % TGT_SET_N];
    roll = $urandom_range(99);
    if (roll < 6) begin
      src = $urandom;
    end else if (roll < 12) begin
      tgt = $urandom;
    end else if (roll < 18) begin
      src = $urandom;
      tgt = $urandom;
    end
    send_request(op, src, tgt, 4'($urandom_range(15)));
  endtask

  task automatic run_phase(int count, int sender_pct, int receiver_pct, int hold);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    hold_left     = hold;
    repeat (count) random_request();
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    func       = FN_ADD;
    source_id  = '0;
    target_id  = '0;
    new_action = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    for (int i = 0; i < SRC_SET_N; i++) src_set[i] = $urandom;
    for (int i = 0; i < TGT_SET_N; i++) tgt_set[i] = $urandom;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_allow_code(4'hF);
    send_request(FN_CHECK,  32'h0000_0000, 32'h0000_0000, 4'h9);
    send_request(FN_REMOVE, 32'h0000_0000, 32'h0000_0000, 4'h3);
    send_request(FN_ADD,    32'h0000_0000, 32'h0000_0000, 4'h0);
    send_request(FN_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
    send_request(FN_ADD,    32'h0000_0000, 32'hFFFF_FFFF, 4'h5);
    send_request(FN_ADD,    32'hFFFF_FFFF, 32'h0000_0000, 4'hA);
    send_request(FN_CHECK,  32'h0000_0000, 32'h0000_0000, 4'hF);
    send_request(FN_CHECK,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'h0);
    send_request(FN_CHECK,  32'h0000_0000, 32'hFFFF_FFFF, 4'h6);
    send_request(FN_CHECK,  32'hFFFF_FFFF, 32'h0000_0000, 4'hC);
    send_request(FN_ADD,    32'h0000_0000, 32'h0000_0000, 4'h7);
    send_request(FN_CHECK,  32'h0000_0000, 32'h0000_0000, 4'h1);
    send_request(FN_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF, 4'hE);
    send_request(FN_ADD,    32'h1234_5678, 32'h9ABC_DEF0, 4'h3);
    send_request(FN_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF, 4'h2);
    send_request(FN_CHECK,  32'h0000_0000, 32'hFFFF_FFFF, 4'h8);
    send_request(FN_CHECK,  32'hA5A5_A5A5, 32'h5A5A_5A5A, 4'h4);
    send_request(FN_CLEAR,  32'h1234_5678, 32'h9ABC_DEF0, 4'hB);
    send_request(FN_CHECK,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hD);
    send_request(FN_CLEAR,  32'hFFFF_FFFF, 32'h0000_0000, 4'h1);
    send_request(FN_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'h0);

    write_allow_code(4'h0);
    run_phase(140, 17, 50, 1000);
    write_allow_code(4'($urandom_range(14, 1)));
    run_phase(130, 50, 17, 0);
    write_allow_code(4'hF);
    run_phase(130, 0, 0, 1000);

    drain_requests();
    repeat (200) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("pair_key_rule_match_table: match");
    end else begin
      $display("pair_key_rule_match_table: mismatch");
    end
    $finish;
  end
endmodule
